// ===== rtl/core/skrt_pkg.sv =====
// ----------------------------------------------------------------------------
// skrt_pkg: shared types and codes for the sorted keyed record table
// Record layout, operation and status codes, sequencer states, compare result.
// ----------------------------------------------------------------------------
package skrt_pkg;

   localparam int CAPACITY_DFLT = 16;

   localparam int ID_W     = 32;
   localparam int AGE_W    = 8;
   localparam int SALARY_W = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic signed [ID_W-1:0] id;
      logic [AGE_W-1:0]       age;
      logic [SALARY_W-1:0]    salary;
   } record_type;

   typedef struct packed {
      logic eq;   // entry id equals key
      logic ge;   // entry id >= key, signed
   } cmp_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WRITE_NEW,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/core/skrt_ifs.sv =====
// ----------------------------------------------------------------------------
// skrt_ifs: request and response channels of the record table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface skrt_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [skrt_pkg::OP_W-1:0]               op;
   logic signed [skrt_pkg::ID_W-1:0]        rec_id;
   logic [skrt_pkg::AGE_W-1:0]              rec_age;
   logic [skrt_pkg::SALARY_W-1:0]           rec_salary;

   modport source (output valid, op, rec_id, rec_age, rec_salary, input ready);
   modport sink   (input valid, op, rec_id, rec_age, rec_salary, output ready);
endinterface

interface skrt_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [skrt_pkg::STATUS_W-1:0]           status;
   logic signed [skrt_pkg::ID_W-1:0]        found_id;
   logic [skrt_pkg::AGE_W-1:0]              found_age;
   logic [skrt_pkg::SALARY_W-1:0]           found_salary;
   logic [skrt_pkg::COUNT_W-1:0]            entry_count;

   modport source (output valid, status, found_id, found_age, found_salary,
                   entry_count, input ready);
   modport sink   (input valid, status, found_id, found_age, found_salary,
                   entry_count, output ready);
endinterface

// ===== rtl/core/skrt_ram.sv =====
// ----------------------------------------------------------------------------
// skrt_ram: record store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skrt_ram #(
   parameter int DEPTH = skrt_pkg::CAPACITY_DFLT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  skrt_pkg::record_type       wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output skrt_pkg::record_type       rd_data
);

   skrt_pkg::record_type mem [DEPTH];
   skrt_pkg::record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/skrt_cmp.sv =====
// ----------------------------------------------------------------------------
// skrt_cmp: shared id comparator
// Signed compare of a stored entry id against the operation key.
// ----------------------------------------------------------------------------
module skrt_cmp (
   input  logic signed [skrt_pkg::ID_W-1:0] entry_id,
   input  logic signed [skrt_pkg::ID_W-1:0] key_id,
   output skrt_pkg::cmp_res_type            res
);

   assign res.eq = (entry_id == key_id);
   assign res.ge = (entry_id >= key_id);

endmodule

// ===== rtl/core/sorted_keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// sorted_keyed_record_table: bounded record table kept in ascending id order
//
//  channel  dir  handshake      payload
//  req_chan in   valid/ready    op, rec_id, rec_age, rec_salary
//  rsp_chan out  valid/ready    status, found_id, found_age, found_salary,
//                               entry_count
//
// Each entry visited takes a memory read, then a compare and move, on the
// store with one write port, one read port and one shared comparator.
// Insert walks down from the top shifting entries up; search and delete walk
// up from the bottom, delete shifting the tail down after the match.
// Reset is synchronous and empties the table; stored data is not cleared.
// req_chan.ready is low while an operation runs; the finished beat waits in
// an output register, so the next request is taken while it stalls.
// ----------------------------------------------------------------------------
module sorted_keyed_record_table #(
   parameter int CAPACITY = skrt_pkg::CAPACITY_DFLT
) (
   input logic          clock,
   input logic          reset,
   skrt_req_if.sink     req_chan,
   skrt_rsp_if.source   rsp_chan
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W+skrt_pkg::COUNT_W-1:0] CAP_WIDE =
      (CNT_W + skrt_pkg::COUNT_W)'(CAPACITY);

   skrt_pkg::state_type               state_ff, state_in;
   logic [skrt_pkg::OP_W-1:0]         op_ff, op_in;
   skrt_pkg::record_type              new_rec_ff, new_rec_in;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              shift_ff, shift_in;
   logic [skrt_pkg::STATUS_W-1:0]     res_status_ff, res_status_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [skrt_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   skrt_pkg::record_type              rsp_rec_ff, rsp_rec_in;
   logic [skrt_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                              ram_we, ram_re;
   logic [IDX_W-1:0]                  ram_waddr;
   skrt_pkg::record_type              ram_wdata, ram_rdata;
   skrt_pkg::cmp_res_type             cmp_res;

   logic                              req_beat;
   logic                              idx_last;
   logic [CNT_W+skrt_pkg::COUNT_W-1:0] count_wide;

   skrt_ram #(.DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   skrt_cmp u_cmp (
      .entry_id (ram_rdata.id),
      .key_id   (new_rec_ff.id),
      .res      (cmp_res)
   );

   assign req_chan.ready = (state_ff == skrt_pkg::ST_IDLE);
   assign req_beat       = req_chan.valid & req_chan.ready;
   assign idx_last       = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign count_wide     = {{skrt_pkg::COUNT_W{1'b0}}, count_ff};

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found_id     = rsp_rec_ff.id;
   assign rsp_chan.found_age    = rsp_rec_ff.age;
   assign rsp_chan.found_salary = rsp_rec_ff.salary;
   assign rsp_chan.entry_count  = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skrt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      new_rec_ff    <= new_rec_in;
      idx_ff        <= idx_in;
      shift_ff      <= shift_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      new_rec_in    = new_rec_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      shift_in      = shift_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = ram_rdata;

      case (state_ff)
         skrt_pkg::ST_IDLE: begin
            if (req_beat) begin
               op_in             = req_chan.op;
               new_rec_in.id     = req_chan.rec_id;
               new_rec_in.age    = req_chan.rec_age;
               new_rec_in.salary = req_chan.rec_salary;
               shift_in          = 1'b0;
               idx_in            = '0;
               res_status_in     = skrt_pkg::STATUS_OK;
               case (req_chan.op)
                  skrt_pkg::OP_INSERT: begin
                     if (count_ff == CAP_CNT) begin
                        res_status_in = skrt_pkg::STATUS_FULL;
                        state_in      = skrt_pkg::ST_RESP;
                     end else if (count_ff == '0) begin
                        state_in = skrt_pkg::ST_WRITE_NEW;
                     end else begin
                        idx_in   = IDX_W'(count_ff - CNT_W'(1));
                        state_in = skrt_pkg::ST_READ;
                     end
                  end
                  skrt_pkg::OP_SEARCH, skrt_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        res_status_in = skrt_pkg::STATUS_NOTFOUND;
                        state_in      = skrt_pkg::ST_RESP;
                     end else begin
                        state_in = skrt_pkg::ST_READ;
                     end
                  end
                  default: begin
                     state_in = skrt_pkg::ST_RESP;
                  end
               endcase
            end
         end

         skrt_pkg::ST_READ: begin
            ram_re   = 1'b1;
            state_in = skrt_pkg::ST_CHECK;
         end

         skrt_pkg::ST_CHECK: begin
            case (op_ff)
               skrt_pkg::OP_INSERT: begin
                  // table is sorted: move entries >= key up until a smaller one
                  if (cmp_res.ge) begin
                     ram_we    = 1'b1;
                     ram_waddr = idx_ff + IDX_W'(1);
                     if (idx_ff == '0) begin
                        state_in = skrt_pkg::ST_WRITE_NEW;
                     end else begin
                        idx_in   = idx_ff - IDX_W'(1);
                        state_in = skrt_pkg::ST_READ;
                     end
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = skrt_pkg::ST_WRITE_NEW;
                  end
               end
               skrt_pkg::OP_SEARCH: begin
                  if (cmp_res.eq) begin
                     state_in = skrt_pkg::ST_RESP;
                  end else if (idx_last) begin
                     res_status_in = skrt_pkg::STATUS_NOTFOUND;
                     state_in      = skrt_pkg::ST_RESP;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = skrt_pkg::ST_READ;
                  end
               end
               skrt_pkg::OP_DELETE: begin
                  if (shift_ff) begin
                     ram_we    = 1'b1;
                     ram_waddr = idx_ff - IDX_W'(1);
                  end
                  if (shift_ff || cmp_res.eq) begin
                     shift_in = 1'b1;
                     if (idx_last) begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = skrt_pkg::ST_RESP;
                     end else begin
                        idx_in   = idx_ff + IDX_W'(1);
                        state_in = skrt_pkg::ST_READ;
                     end
                  end else if (idx_last) begin
                     res_status_in = skrt_pkg::STATUS_NOTFOUND;
                     state_in      = skrt_pkg::ST_RESP;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = skrt_pkg::ST_READ;
                  end
               end
               default: begin
                  state_in = skrt_pkg::ST_RESP;
               end
            endcase
         end

         skrt_pkg::ST_WRITE_NEW: begin
            ram_we    = 1'b1;
            ram_wdata = new_rec_ff;
            count_in  = count_ff + CNT_W'(1);
            state_in  = skrt_pkg::ST_RESP;
         end

         skrt_pkg::ST_RESP: begin
            // read data still holds the matched entry of a search
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_wide[skrt_pkg::COUNT_W-1:0];
               if (op_ff == skrt_pkg::OP_SEARCH &&
                   res_status_ff == skrt_pkg::STATUS_OK) begin
                  rsp_rec_in = ram_rdata;
               end else begin
                  rsp_rec_in = '0;
               end
               state_in = skrt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = skrt_pkg::ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count beyond capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) ||
                count_ff == $past(count_ff) + CNT_W'(1) ||
                count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff != skrt_pkg::ST_IDLE)
      else $error("request beat did not start an operation");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == skrt_pkg::STATUS_FULL) |->
         rsp_count_ff == CAP_WIDE[skrt_pkg::COUNT_W-1:0])
      else $error("full status with table not full");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != skrt_pkg::STATUS_OK) |->
         rsp_rec_ff == '0)
      else $error("found fields set on a failed operation");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sorted keyed record table
// Drives insert, search, delete and unused-op beats with random gaps and checks every
// response against a predictor of the sorted table, including a long
// response hold-off that backs the block up into its request channel.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CAP            = skrt_pkg::CAPACITY_DFLT;
   localparam int CLK_HALF       = 4;
   localparam int DRAIN_CYCLES   = 2 * CAP + 12;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int RANDOM_ITEMS   = 900;
   localparam int KEY_POOL       = 16;
   localparam int HOLD_AT        = 200;
   localparam int HOLD_CYCLES    = 300;
   localparam logic [skrt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [skrt_pkg::OP_W-1:0]        op;
      logic signed [skrt_pkg::ID_W-1:0] id;
      logic [skrt_pkg::AGE_W-1:0]       age;
      logic [skrt_pkg::SALARY_W-1:0]    salary;
   } table_req_type;

   typedef struct {
      logic [skrt_pkg::STATUS_W-1:0]    status;
      logic signed [skrt_pkg::ID_W-1:0] found_id;
      logic [skrt_pkg::AGE_W-1:0]       found_age;
      logic [skrt_pkg::SALARY_W-1:0]    found_salary;
      logic [skrt_pkg::COUNT_W-1:0]     entry_count;
   } table_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   skrt_req_if req_chan ();
   skrt_rsp_if rsp_chan ();

   sorted_keyed_record_table u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLK_HALF) clock = ~clock;

   table_req_type pending_reqs[$];
   table_rsp_type expected_rsps[$];
   table_req_type offered;
   int unsigned   fail_count = 0;
   int unsigned   req_beats  = 0;
   int unsigned   rsp_beats  = 0;
   int unsigned   send_gap   = 0;
   int unsigned   stall_left = 0;
   logic signed [skrt_pkg::ID_W-1:0] key_pool[KEY_POOL];

   // predictor state: records in ascending signed id order
   skrt_pkg::record_type held_recs[CAP];
   int unsigned          held_num = 0;

   task automatic table_apply(input table_req_type rq, output table_rsp_type rs);
      int unsigned pos;
      rs.status       = skrt_pkg::STATUS_OK;
      rs.found_id     = '0;
      rs.found_age    = '0;
      rs.found_salary = '0;
      pos = 0;
      case (rq.op)
         skrt_pkg::OP_INSERT: begin
            if (held_num >= CAP) begin
               rs.status = skrt_pkg::STATUS_FULL;
            end else begin
               // new record goes ahead of the first id >= its own
               while (pos < held_num && $signed(held_recs[pos].id) < rq.id) pos++;
               for (int unsigned i = held_num; i > pos; i--) held_recs[i] = held_recs[i-1];
               held_recs[pos].id     = rq.id;
               held_recs[pos].age    = rq.age;
               held_recs[pos].salary = rq.salary;
               held_num++;
            end
         end
         skrt_pkg::OP_SEARCH, skrt_pkg::OP_DELETE: begin
            while (pos < held_num && held_recs[pos].id != rq.id) pos++;
            if (pos >= held_num) begin
               rs.status = skrt_pkg::STATUS_NOTFOUND;
            end else if (rq.op == skrt_pkg::OP_SEARCH) begin
               rs.found_id     = held_recs[pos].id;
               rs.found_age    = held_recs[pos].age;
               rs.found_salary = held_recs[pos].salary;
            end else begin
               for (int unsigned i = pos; i + 1 < held_num; i++) held_recs[i] = held_recs[i+1];
               held_num--;
            end
         end
         default: begin
         end
      endcase
      rs.entry_count = held_num[skrt_pkg::COUNT_W-1:0];
   endtask

   task automatic push_req(input logic [skrt_pkg::OP_W-1:0] op,
                           input logic signed [skrt_pkg::ID_W-1:0] id,
                           input logic [skrt_pkg::AGE_W-1:0] age,
                           input logic [skrt_pkg::SALARY_W-1:0] salary);
      table_req_type rq;
      rq.op     = op;
      rq.id     = id;
      rq.age    = age;
      rq.salary = salary;
      pending_reqs.push_back(rq);
   endtask

   // mostly short gaps, a few long ones, and every fourth stretch of 128 beats without any
   function automatic int unsigned pick_gap(input int unsigned beats);
      int unsigned r;
      r = $urandom_range(0, 99);
      if ((beats / 128) % 4 == 3) return 0;
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [skrt_pkg::ID_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, KEY_POOL - 1)];
      return $urandom;
   endfunction

   task automatic check_rsp(input table_rsp_type exp_rsp);
      if (rsp_chan.status !== exp_rsp.status) begin
         $error("status: expected %0d, got %0d", exp_rsp.status, rsp_chan.status);
         fail_count++;
      end
      if (rsp_chan.found_id !== exp_rsp.found_id) begin
         $error("found_id: expected %0d, got %0d", exp_rsp.found_id, rsp_chan.found_id);
         fail_count++;
      end
      if (rsp_chan.found_age !== exp_rsp.found_age) begin
         $error("found_age: expected %0d, got %0d", exp_rsp.found_age, rsp_chan.found_age);
         fail_count++;
      end
      if (rsp_chan.found_salary !== exp_rsp.found_salary) begin
         $error("found_salary: expected %0d, got %0d",
                exp_rsp.found_salary, rsp_chan.found_salary);
         fail_count++;
      end
      if (rsp_chan.entry_count !== exp_rsp.entry_count) begin
         $error("entry_count: expected %0d, got %0d",
                exp_rsp.entry_count, rsp_chan.entry_count);
         fail_count++;
      end
   endtask

   // driver: request side
   always @(posedge clock) begin
      table_rsp_type rs;
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.op         <= skrt_pkg::OP_INSERT;
         req_chan.rec_id     <= '0;
         req_chan.rec_age    <= '0;
         req_chan.rec_salary <= '0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            table_apply(offered, rs);
            expected_rsps.push_back(rs);
            req_beats++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               offered = pending_reqs.pop_front();
               req_chan.op         <= offered.op;
               req_chan.rec_id     <= offered.id;
               req_chan.rec_age    <= offered.age;
               req_chan.rec_salary <= offered.salary;
               req_chan.valid      <= 1'b1;
               send_gap = pick_gap(req_beats);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_beats++;
            if (expected_rsps.size() == 0) begin
               $error("response beat with nothing expected: status %0d count %0d",
                      rsp_chan.status, rsp_chan.entry_count);
               fail_count++;
            end else begin
               check_rsp(expected_rsps.pop_front());
            end
            // one long hold-off so the output register fills and requests back up
            if (rsp_beats == HOLD_AT) stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap(rsp_beats);
         end
      end
   end

   initial begin
      int unsigned r;
      int unsigned ins_pct;
      logic [skrt_pkg::OP_W-1:0] op;
      logic [skrt_pkg::AGE_W-1:0] age;
      logic [skrt_pkg::SALARY_W-1:0] salary;

      key_pool[0] = 32'sh7FFF_FFFF;
      key_pool[1] = 32'sh8000_0000;
      key_pool[2] = 0;
      key_pool[3] = -1;
      for (int i = 4; i < KEY_POOL; i++)
         key_pool[i] = (i % 2) ? $signed($urandom) : $signed($urandom_range(0, 40)) - 20;

      // directed: empty table, id extremes, duplicate ordering, unused op, fill up
      push_req(skrt_pkg::OP_SEARCH, 5, 8'd0, 32'd0);
      push_req(skrt_pkg::OP_DELETE, 5, 8'd0, 32'd0);
      push_req(skrt_pkg::OP_INSERT, 32'sh7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      push_req(skrt_pkg::OP_INSERT, 32'sh8000_0000, 8'h00, 32'h0000_0000);
      push_req(skrt_pkg::OP_INSERT, -1, 8'd1, 32'd1);
      push_req(skrt_pkg::OP_INSERT, 0, 8'd10, 32'd1000);
      push_req(skrt_pkg::OP_INSERT, 0, 8'd20, 32'd2000);
      push_req(skrt_pkg::OP_SEARCH, 0, 8'hFF, 32'hFFFF_FFFF);
      push_req(skrt_pkg::OP_SEARCH, 32'sh7FFF_FFFF, 8'd0, 32'd0);
      push_req(skrt_pkg::OP_SEARCH, 32'sh8000_0000, 8'd0, 32'd0);
      push_req(skrt_pkg::OP_DELETE, 0, 8'd0, 32'd0);
      push_req(skrt_pkg::OP_SEARCH, 0, 8'd0, 32'd0);
      push_req(OP_UNUSED, $signed($urandom), 8'hA5, $urandom);
      for (int i = 0; i < CAP - 4; i++)
         push_req(skrt_pkg::OP_INSERT, $signed($urandom_range(0, 64)) - 32,
                  skrt_pkg::AGE_W'($urandom), $urandom);
      push_req(skrt_pkg::OP_INSERT, 7, 8'd7, 32'd7);
      push_req(skrt_pkg::OP_SEARCH, 32'sh7FFF_FFFF, 8'd0, 32'd0);

      // random: insert/delete balance drifts so the table swings between empty and full
      ins_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) ins_pct = $urandom_range(15, 80);
         r = $urandom_range(0, 99);
         if (r < 3) op = OP_UNUSED;
         else if (r < 3 + ins_pct) op = skrt_pkg::OP_INSERT;
         else if ($urandom_range(0, 1)) op = skrt_pkg::OP_SEARCH;
         else op = skrt_pkg::OP_DELETE;
         case ($urandom_range(0, 9))
            0: begin age = 8'h00; salary = 32'h0000_0000; end
            1: begin age = 8'hFF; salary = 32'hFFFF_FFFF; end
            default: begin age = skrt_pkg::AGE_W'($urandom); salary = $urandom; end
         endcase
         push_req(op, pick_key(), age, salary);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_chan.valid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("testbench: errors");
      $finish;
   end

endmodule
